// ===== rtl/trd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trd_pkg: shared types and constants of the trial division prime test
// Status of the serial divider as seen by the sequencer, and the fixed
// constants of the divisor sweep.
// ----------------------------------------------------------------------------
package trd_pkg;

	// status of the bit-serial divider
	typedef struct packed {
		logic busy;   // division in progress
		logic done;   // quotient and remainder valid this cycle (one-cycle pulse)
	} trd_div_status_t;

	// first trial divisor and its increment (odd divisors only)
	localparam int FIRST_DIVISOR = 3;
	localparam int DIVISOR_STEP  = 2;

endpackage : trd_pkg
`default_nettype wire

// ===== rtl/trd_cand_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trd_cand_if: candidate channel
// Valid/ready channel that carries one integer to be tested.
// ----------------------------------------------------------------------------
interface trd_cand_if #(
	parameter int VALUE_WIDTH = 31
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink   (input valid, input candidate, output ready);
endinterface : trd_cand_if
`default_nettype wire

// ===== rtl/trd_flag_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trd_flag_if: result channel
// Valid/ready channel that carries the one-bit prime flag.
// ----------------------------------------------------------------------------
interface trd_flag_if;
	logic valid;
	logic ready;
	logic prime_flag;

	modport source (output valid, output prime_flag, input ready);
	modport sink   (input valid, input prime_flag, output ready);
endinterface : trd_flag_if
`default_nettype wire

// ===== rtl/trd_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trd_divider: bit-serial restoring divider
// Produces quotient and remainder one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module trd_divider #(
	parameter int VALUE_WIDTH = 31
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         start,
	input  wire  [VALUE_WIDTH-1:0]      dividend,
	input  wire  [VALUE_WIDTH-1:0]      divisor,
	output trd_pkg::trd_div_status_t    status,
	output logic [VALUE_WIDTH-1:0]      quotient,
	output logic [VALUE_WIDTH-1:0]      remainder
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [VALUE_WIDTH-1:0] div_q;

	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH:0]   diff;
	logic                   fits;

	// shift the next dividend bit into the partial remainder, try to subtract
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = ~diff[VALUE_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
		end
	end

	assign status    = '{busy: busy_q, done: done_q};
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule : trd_divider
`default_nettype wire

// ===== rtl/trial_division_prime_test_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit: trial division primality tester
// Tests one unsigned integer per item and answers with a prime flag.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)   : one candidate per transfer, VALUE_WIDTH bits unsigned.
//   out_ch (source) : one prime_flag per candidate, in order.
//   Values below 2 and even values, 2 included, are answered directly:
//   they go from S_IDLE straight to S_DONE. Odd values sweep the
//   divisors 3, 5, 7, ... through one bit-serial divider that yields
//   quotient and remainder for each divisor, passing S_LOAD, S_DIV and
//   S_EVAL per divisor. The sweep stops when the divisor exceeds the
//   quotient (past the square root, prime) or the remainder is zero
//   (composite). For a 31-bit prime near the top of the range the sweep
//   runs through about 23000 divisors, one division for each.
//   One candidate is in work at a time; the next one is taken as soon as
//   the result has moved to the output register, even if the receiver has
//   not taken it yet. While out_ch.ready is low the result holds in the
//   output register and a finished sweep waits for it to free.
//   Reset (arst_n low) drops any item in work and any pending result.
// ----------------------------------------------------------------------------
module trial_division_prime_test_unit #(
	parameter int VALUE_WIDTH = 31
) (
	input  wire          clk,
	input  wire          arst_n,
	trd_cand_if.sink     in_ch,
	trd_flag_if.source   out_ch
);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;  // wait for a candidate
	localparam logic [2:0] S_LOAD = 3'd1;  // start a division
	localparam logic [2:0] S_DIV  = 3'd2;  // division running
	localparam logic [2:0] S_EVAL = 3'd3;  // judge quotient and remainder
	localparam logic [2:0] S_DONE = 3'd4;  // hand result to output register

	logic [2:0]             state_q;
	logic [VALUE_WIDTH-1:0] n_q;        // candidate under test
	logic [VALUE_WIDTH-1:0] d_q;        // current trial divisor
	logic                   result_q;   // flag of the finished sweep
	logic                   out_valid_q;
	logic                   flag_q;

	trd_pkg::trd_div_status_t div_st;
	logic [VALUE_WIDTH-1:0]   quo;
	logic [VALUE_WIDTH-1:0]   rem;
	logic                     div_start;
	logic                     in_fire;
	logic                     out_fire;
	logic                     out_free;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign out_fire  = out_valid_q && out_ch.ready;
	// output register can take a new result this cycle
	assign out_free  = !out_valid_q || out_ch.ready;
	assign div_start = (state_q == S_LOAD) && !div_st.busy;

	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.prime_flag = flag_q;

	trd_divider #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (d_q),
		.status    (div_st),
		.quotient  (quo),
		.remainder (rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						// small and even values need no division
						if (in_ch.candidate < VALUE_WIDTH'(2) || !in_ch.candidate[0]) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					if (div_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					// divisor past the square root, or an exact divisor: stop
					if (d_q > quo || rem == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_LOAD;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath of the sweep
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_fire) begin
			n_q      <= in_ch.candidate;
			d_q      <= VALUE_WIDTH'(trd_pkg::FIRST_DIVISOR);
			// 2 is the only even prime
			result_q <= (in_ch.candidate == VALUE_WIDTH'(2));
		end else if (state_q == S_EVAL) begin
			if (d_q > quo) begin
				result_q <= 1'b1;
			end else if (rem == '0) begin
				result_q <= 1'b0;
			end
			d_q <= d_q + VALUE_WIDTH'(trd_pkg::DIVISOR_STEP);
		end
	end

	// output register: load a finished result, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			flag_q <= result_q;
		end
	end

endmodule : trial_division_prime_test_unit
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for trial_division_prime_test_unit
// Offers candidates on the candidate channel and predicts a prime flag for
// each accepted one. Every flag that comes back is compared, in order, with
// the oldest prediction. A short directed run covers the corner values. A
// random run follows, mostly with small values so that the divisor sweeps
// stay short. Both channels idle at random, and the receiver holds off once
// long enough to fill the block.
// ----------------------------------------------------------------------------

// Prediction store: computes the flag for every accepted candidate and checks
// returned flags against those predictions in order.
class prime_scoreboard;
	bit          expected_flags[$];
	int unsigned flags_seen;
	int unsigned mismatches;
	int unsigned primes_seen;
	int unsigned composites_seen;
	longint unsigned largest_candidate;

	function new();
		flags_seen        = 0;
		mismatches        = 0;
		primes_seen       = 0;
		composites_seen   = 0;
		largest_candidate = 0;
	endfunction

	// Trial division. Bounding with d <= n / d never forms the square.
	function bit predict_flag(longint unsigned n);
		longint unsigned d;
		if (n < 2) return 1'b0;
		if (n == 2) return 1'b1;
		if (n[0] == 1'b0) return 1'b0;
		if (n > 6 && (n % 6) != 1 && (n % 6) != 5) return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	function void note_candidate(longint unsigned value);
		expected_flags.push_back(predict_flag(value));
		if (value > largest_candidate) largest_candidate = value;
	endfunction

	function void check_flag(logic actual);
		bit want;
		flags_seen++;
		if (expected_flags.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] unexpected prime_flag %b with nothing outstanding",
					$realtime, actual);
			return;
		end
		want = expected_flags.pop_front();
		if (actual !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] prime_flag mismatch on result %0d: expected %b, got %b",
					$realtime, flags_seen, want, actual);
		end
		if (want) primes_seen++;
		else composites_seen++;
	endfunction
endclass

module testbench;

	localparam int          VALUE_WIDTH   = 31;
	localparam int          RANDOM_ITEMS  = 80;
	// Longer than two of the slowest random sweeps, so the block surely fills.
	localparam int          HOLD_CYCLES   = 40_000;
	// Extra wait after draining, sized in divisor steps, to catch stray flags.
	localparam int          DRAIN_CYCLES  = 4 * (VALUE_WIDTH + 3);
	// The slowest item, 2^31-1, sweeps about 23000 divisors; the limit leaves
	// room for it and the rest of the run.
	localparam int unsigned CYCLE_LIMIT   = 8_000_000;
	localparam int unsigned IDLE_PERCENT  = 31;

	localparam longint unsigned MAX_VALUE = (64'd1 << VALUE_WIDTH) - 1;

	// Small odd primes used to build large composites that fail early.
	localparam int SMALL_FACTORS [14] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31,
		37, 41, 43, 47};

	logic clk;
	logic arst_n;

	trd_cand_if #(.VALUE_WIDTH(VALUE_WIDTH)) cand_ch ();
	trd_flag_if                              flag_ch ();

	trial_division_prime_test_unit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (cand_ch),
		.out_ch (flag_ch)
	);

	prime_scoreboard sb;
	int unsigned     hold_cycles_done;

	// 12 ns clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Hold reset low at start, release it on a falling edge, away from the active edge.
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Stop a hung run.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL trial_division_prime_test_unit");
		$finish;
	end

	// Offer one candidate and hold it until the block takes it. Afterwards,
	// if idling is allowed, sometimes drop valid for a short random gap.
	task automatic send_candidate(input longint unsigned value, input bit may_idle);
		cand_ch.valid     <= 1'b1;
		cand_ch.candidate <= value[VALUE_WIDTH-1:0];
		do @(posedge clk); while (!cand_ch.ready);
		sb.note_candidate(value & MAX_VALUE);
		if (may_idle && $urandom_range(99) < IDLE_PERCENT) begin
			cand_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Advance until every predicted flag has come back.
	task automatic wait_until_drained();
		while (sb.expected_flags.size() != 0) @(posedge clk);
	endtask

	// Pick a random candidate. Keep most sweeps short: small values, even
	// values of any size (answered at once), and large values with a small
	// factor. Only a few other odd values go up to 2^20.
	function automatic longint unsigned pick_candidate();
		int unsigned     sel;
		int unsigned     factor;
		longint unsigned product;
		sel = $urandom_range(99);
		if (sel < 35) begin
			return 64'($urandom_range(0, 4095));
		end else if (sel < 55) begin
			return 64'($urandom_range(0, 32767) | 1);
		end else if (sel < 75) begin
			return 64'($urandom) & MAX_VALUE & ~64'd1;
		end else if (sel < 92) begin
			factor  = SMALL_FACTORS[$urandom_range(0, 13)];
			product = 64'(factor) * 64'($urandom_range(1, 32'(MAX_VALUE / factor)));
			return product;
		end else begin
			return 64'($urandom_range(0, (1 << 20) - 1) | 1);
		end
	endfunction

	// Result side: check each transfer, then pick ready for the next edge.
	// Once, hold ready low for a long stretch while candidates keep coming,
	// so the block fills and stalls its input. Keep ready high over a window
	// of results so that there is also a run without idling.
	initial begin : flag_sink
		int unsigned hold_left;
		bit          hold_started;
		hold_left        = 0;
		hold_started     = 1'b0;
		hold_cycles_done = 0;
		flag_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (flag_ch.valid && flag_ch.ready) sb.check_flag(flag_ch.prime_flag);
			if (!hold_started && sb.flags_seen >= 30) begin
				hold_started = 1'b1;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				hold_cycles_done++;
				flag_ch.ready <= 1'b0;
			end else if (sb.flags_seen >= 50 && sb.flags_seen < 80) begin
				flag_ch.ready <= 1'b1;
			end else begin
				flag_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	// Candidate side and end of run.
	initial begin : candidate_source
		longint unsigned corner_values [$];
		sb = new();
		cand_ch.valid     <= 1'b0;
		cand_ch.candidate <= '0;
		@(posedge arst_n);
		@(posedge clk);

		// Corner values: below 2, the only even prime, small primes and
		// odd multiples of 3 around the mod-6 filter, prime squares right
		// on the sweep bound, and the top of the range (2^31-1 is prime and
		// runs the longest sweep).
		corner_values = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 15, 21, 25, 35, 49, 121,
			65521, 1042441, 1431655765, MAX_VALUE - 2, MAX_VALUE - 1, MAX_VALUE};
		foreach (corner_values[i]) send_candidate(corner_values[i], 1'b1);

		// Pause the sender until every directed result is back.
		cand_ch.valid <= 1'b0;
		wait_until_drained();
		@(posedge clk);

		// Random part; items 30..54 go back to back.
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_candidate(pick_candidate(), !(i >= 30 && i < 55));
		cand_ch.valid <= 1'b0;

		// Let the last results arrive and watch for stray ones.
		wait_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Tested %0d candidates: %0d prime, %0d composite, largest %0d.",
			sb.flags_seen, sb.primes_seen, sb.composites_seen, sb.largest_candidate);
		$display("Receiver held off %0d cycles in one stretch; %0d mismatches.",
			hold_cycles_done, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_flags.size() == 0) begin
			$display("PASS trial_division_prime_test_unit");
		end else begin
			$display("FAIL trial_division_prime_test_unit");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/trd_pkg.sv
rtl/trd_cand_if.sv
rtl/trd_flag_if.sv
rtl/trd_divider.sv
rtl/trial_division_prime_test_unit.sv
dv/testbench.sv
